FILE: hw/rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue unit.
package deq_pkg;

  // Default geometry
  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed port field widths
  localparam int VALUE_W = 32;
  localparam int OP_W    = 3;

  // Operation codes carried on the input tuser
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP_FWD   = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP_BWD   = 3'd5;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_ROT_LEFT,
    CMD_ROT_RIGHT
  } cell_cmd_e;

endpackage

FILE: hw/rtl/deq_cell.sv
// One storage cell of the deque chain: a word, its valid bit, neighbor links.
module deq_cell #(
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  deq_pkg::cell_cmd_e    cmd_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,   // toward the front
  input  logic                  left_valid_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,  // toward the back
  input  logic                  right_valid_i,
  input  logic [DATA_WIDTH-1:0] push_data_i,   // word for a back push
  input  logic [DATA_WIDTH-1:0] wrap_data_i,   // front word, for left rotation
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  valid_o,
  output logic                  tail_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  valid_q, valid_d;

  // Next-state selection per command
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    unique case (cmd_i)
      deq_pkg::CMD_PUSH_FRONT: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      deq_pkg::CMD_PUSH_BACK: begin
        // first empty cell behind an occupied one takes the word
        if (!valid_q && left_valid_i) begin
          data_d  = push_data_i;
          valid_d = 1'b1;
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      deq_pkg::CMD_POP_BACK: begin
        if (valid_q && !right_valid_i) begin
          valid_d = 1'b0;
        end
      end
      deq_pkg::CMD_ROT_LEFT: begin
        // tail cell takes the old front word
        if (valid_q) begin
          data_d = right_valid_i ? right_data_i : wrap_data_i;
        end
      end
      deq_pkg::CMD_ROT_RIGHT: begin
        if (valid_q) begin
          data_d = left_data_i;
        end
      end
      default: begin
      end
    endcase
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stored word, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign tail_o  = valid_q && !right_valid_i;

endmodule

FILE: hw/rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue: control, cell chain and output register.
//
//  Channel   | Dir | Payload                                   | Transfer
//  s_axis    | in  | tdata: value[31:0]; tuser: operation[2:0]  | tvalid & tready
//  m_axis    | out | tdata: value_res[31:0]; tuser: empty_res,  | tvalid & tready
//            |     |   overflowed (bit 0 up); tlast: last       |
//
// Pushes and pops are registered into the cell chain; a new item is accepted
// every cycle while no dump runs. A dump holds the input until its N stored
// words (one when empty) are out, one per cycle while the output slot is free:
// the chain rotates by one cell per emitted word. Reset clears all valid bits,
// the count and the overflow flag at once. A stalled output register stalls
// the dump rotation; pushes and pops keep flowing while a single result waits.
module double_ended_queue_unit #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [deq_pkg::VALUE_W-1:0]  s_axis_tdata,   // value
  input  logic [deq_pkg::OP_W-1:0]     s_axis_tuser,   // operation
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [deq_pkg::VALUE_W-1:0]  m_axis_tdata,   // value_res
  output logic [1:0]                   m_axis_tuser,   // empty_res, overflowed
  output logic                         m_axis_tlast    // last
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  // Control state
  logic                busy_q, busy_d;
  logic                bwd_q, bwd_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     remain_q, remain_d;
  logic                ovf_q, ovf_d;

  // Output register
  logic                        out_valid_q, out_valid_d;
  logic [deq_pkg::VALUE_W-1:0] out_data_q, out_data_d;
  logic                        out_empty_q, out_empty_d;
  logic                        out_ovf_q, out_ovf_d;
  logic                        out_last_q, out_last_d;

  deq_pkg::cell_cmd_e  cmd;
  logic                in_xfer;
  logic                slot_free;
  logic                full;

  // Chain links
  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic                  cell_valid [DEPTH];
  logic                  cell_tail  [DEPTH];
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] head_left;
  logic [DATA_WIDTH-1:0] tail_data;
  logic [deq_pkg::VALUE_W-1:0] front_val;
  logic [deq_pkg::VALUE_W-1:0] tail_val;

  assign s_axis_tready = !busy_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign full          = (count_q == CntFull);

  // Stored word from the input, and stored word back to the port width
  if (DATA_WIDTH <= deq_pkg::VALUE_W) begin : g_narrow
    assign push_word = s_axis_tdata[DATA_WIDTH-1:0];
    assign front_val = deq_pkg::VALUE_W'(cell_data[0]);
    assign tail_val  = deq_pkg::VALUE_W'(tail_data);
  end else begin : g_wide
    assign push_word = {{(DATA_WIDTH - deq_pkg::VALUE_W){s_axis_tdata[deq_pkg::VALUE_W-1]}},
                        s_axis_tdata};
    assign front_val = cell_data[0][deq_pkg::VALUE_W-1:0];
    assign tail_val  = tail_data[deq_pkg::VALUE_W-1:0];
  end

  // Tail tap: one-hot select of the last occupied cell
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_data = tail_data | ({DATA_WIDTH{cell_tail[i]}} & cell_data[i]);
    end
  end

  // Front cell's left input: new word for front push, tail word for right rotation
  assign head_left = (cmd == deq_pkg::CMD_ROT_RIGHT) ? tail_data : push_word;

  // Command decode and control next state
  always_comb begin
    cmd         = deq_pkg::CMD_HOLD;
    busy_d      = busy_q;
    bwd_d       = bwd_q;
    count_d     = count_q;
    remain_d    = remain_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_empty_d = out_empty_q;
    out_ovf_d   = out_ovf_q;
    out_last_d  = out_last_q;

    if (busy_q) begin
      if (slot_free) begin
        out_valid_d = 1'b1;
        // flag as it stands when the word is emitted
        out_ovf_d   = ovf_q;
        if (count_q == '0) begin
          // dump of an empty queue
          out_data_d  = '0;
          out_empty_d = 1'b1;
          out_last_d  = 1'b1;
          busy_d      = 1'b0;
        end else begin
          cmd         = bwd_q ? deq_pkg::CMD_ROT_RIGHT : deq_pkg::CMD_ROT_LEFT;
          out_data_d  = bwd_q ? tail_val : front_val;
          out_empty_d = 1'b0;
          out_last_d  = (remain_q == CntOne);
          remain_d    = remain_q - CntOne;
          busy_d      = (remain_q != CntOne);
        end
      end
    end else if (in_xfer) begin
      unique case (s_axis_tuser) inside
        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cmd     = (s_axis_tuser == deq_pkg::OP_PUSH_FRONT) ?
                      deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK;
            count_d = count_q + CntOne;
          end
        end
        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
          if (count_q != '0) begin
            cmd     = (s_axis_tuser == deq_pkg::OP_POP_FRONT) ?
                      deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_BACK;
            count_d = count_q - CntOne;
          end
        end
        deq_pkg::OP_DUMP_FWD, deq_pkg::OP_DUMP_BWD: begin
          busy_d   = 1'b1;
          bwd_d    = (s_axis_tuser == deq_pkg::OP_DUMP_BWD);
          remain_d = count_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      bwd_q       <= 1'b0;
      count_q     <= '0;
      remain_q    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      bwd_q       <= bwd_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_empty_q <= out_empty_d;
    out_ovf_q   <= out_ovf_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_ovf_q, out_empty_q};
  assign m_axis_tlast  = out_last_q;

  // Cell chain, front at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic                  left_valid;
    logic [DATA_WIDTH-1:0] right_data;
    logic                  right_valid;

    if (i == 0) begin : g_first
      assign left_data  = head_left;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .push_data_i   (push_word),
      .wrap_data_i   (cell_data[0]),
      .data_o        (cell_data[i]),
      .valid_o       (cell_valid[i]),
      .tail_o        (cell_tail[i])
    );
  end

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull) else $error("count exceeds depth");

  a_front_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[0] == (count_q != '0)) else $error("front valid disagrees with count");

  a_back_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[DEPTH-1] == full) else $error("back valid disagrees with count");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q) else $error("overflow flag cleared");

  a_dump_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> $stable(count_q)) else $error("count moved during dump");

endmodule

FILE: tb/double_ended_queue_unit_test.sv
// Self-checking testbench for the double-ended queue unit: ring predictor, random traffic.
module double_ended_queue_unit_test;
  import deq_pkg::*;

  localparam int          QDEPTH      = DEPTH_DEFAULT;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 1_200_000;

  // Operation codes the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

  // One word emitted by a dump, as the output channel carries it
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               empty;
    logic               overflowed;
    logic               last;
  } dump_word_t;

  // Ring-buffer predictor plus the queue of dump words still to arrive
  class deque_scoreboard;
    logic [VALUE_W-1:0] ring[QDEPTH];
    int unsigned        front;
    int unsigned        fill;
    logic               overflow_seen;
    dump_word_t         dump_words_q[$];
    int unsigned        mismatches;

    function new();
      front         = 0;
      fill          = 0;
      overflow_seen = 1'b0;
      mismatches    = 0;
    endfunction

    function int unsigned pending();
      return dump_words_q.size();
    endfunction

    // Apply one accepted operation and queue the words a dump will emit
    function void note_operation(logic [OP_W-1:0] op, logic [VALUE_W-1:0] word);
      int unsigned pos;
      dump_word_t  entry;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (fill == QDEPTH) begin
            overflow_seen = 1'b1;
          end else if (op == OP_PUSH_FRONT) begin
            front       = (front + QDEPTH - 1) % QDEPTH;
            ring[front] = word;
            fill++;
          end else begin
            ring[(front + fill) % QDEPTH] = word;
            fill++;
          end
        end
        OP_POP_FRONT: begin
          if (fill != 0) begin
            front = (front + 1) % QDEPTH;
            fill--;
          end
        end
        OP_POP_BACK: begin
          if (fill != 0) fill--;
        end
        OP_DUMP_FWD, OP_DUMP_BWD: begin
          entry.overflowed = overflow_seen;
          if (fill == 0) begin
            entry.value = '0;
            entry.empty = 1'b1;
            entry.last  = 1'b1;
            dump_words_q.push_back(entry);
          end else begin
            for (int i = 0; i < fill; i++) begin
              pos         = (op == OP_DUMP_FWD) ? i : fill - 1 - i;
              entry.value = ring[(front + pos) % QDEPTH];
              entry.empty = 1'b0;
              entry.last  = (i + 1 == fill);
              dump_words_q.push_back(entry);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one output transfer with the oldest expected word
    function void check_output(logic [VALUE_W-1:0] data, logic [1:0] user, logic tlast);
      dump_word_t want;
      if (dump_words_q.size() == 0) begin
        $error("unexpected output transfer: value_res %0d", $signed(data));
        mismatches++;
        return;
      end
      want = dump_words_q.pop_front();
      if (data !== want.value) begin
        $error("value_res: expected %0d, actual %0d", $signed(want.value), $signed(data));
        mismatches++;
      end
      if (user[0] !== want.empty) begin
        $error("empty_res: expected %0b, actual %0b", want.empty, user[0]);
        mismatches++;
      end
      if (user[1] !== want.overflowed) begin
        $error("overflowed: expected %0b, actual %0b", want.overflowed, user[1]);
        mismatches++;
      end
      if (tlast !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, tlast);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [VALUE_W-1:0] s_axis_tdata;   // value
  logic [OP_W-1:0]    s_axis_tuser;   // operation
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [VALUE_W-1:0] m_axis_tdata;   // value_res
  logic [1:0]         m_axis_tuser;   // empty_res, overflowed
  logic               m_axis_tlast;   // last

  deque_scoreboard sb = new();
  bit              calm     = 1'b0;   // no idling on either side
  bit              hold_req = 1'b0;   // ask the sink for one long stall

  always #6 clk_i = ~clk_i;

  double_ended_queue_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Mostly random words, with the signed extremes mixed in
  function automatic logic [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Weighted operation pick; a small remainder goes to the unused codes
  function automatic logic [OP_W-1:0] pick_op(int unsigned push_w, int unsigned pop_w,
                                              int unsigned dump_w);
    int unsigned r;
    r = $urandom_range(0, push_w + pop_w + dump_w);
    if (r < push_w) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < push_w + pop_w) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    if (r < push_w + pop_w + dump_w) return $urandom_range(0, 1) ? OP_DUMP_BWD : OP_DUMP_FWD;
    return $urandom_range(0, 1) ? OP_UNUSED_B : OP_UNUSED_A;
  endfunction

  // Offer one item, with an occasional idle burst ahead of it
  task automatic send_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] word);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_operation(op, word);
  endtask

  task automatic run_mix(input int n, input int unsigned push_w, input int unsigned pop_w,
                         input int unsigned dump_w);
    for (int i = 0; i < n; i++) send_op(pick_op(push_w, pop_w, dump_w), rand_word());
  endtask

  // Stop offering until every dump word has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_PUSH_FRONT;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue, unused codes, extremes, both dump directions
    send_op(OP_DUMP_FWD, '1);
    send_op(OP_DUMP_BWD, '0);
    send_op(OP_POP_FRONT, 32'h1234_5678);
    send_op(OP_POP_BACK, '1);
    send_op(OP_UNUSED_A, 32'hDEAD_BEEF);
    send_op(OP_UNUSED_B, '1);
    send_op(OP_DUMP_FWD, '0);
    send_op(OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_op(OP_PUSH_FRONT, 32'h8000_0000);
    send_op(OP_PUSH_BACK, '0);
    send_op(OP_PUSH_FRONT, '1);
    send_op(OP_DUMP_FWD, '0);
    send_op(OP_DUMP_BWD, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_DUMP_FWD, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_DUMP_BWD, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_DUMP_BWD, '0);

    // General mix, growing the queue
    run_mix(55, 20, 8, 8);

    // Sink holds off while items keep coming, so dumps back up the input
    hold_req = 1'b1;
    run_mix(20, 14, 0, 6);
    wait_drained();

    // Fill to capacity, then push past it to raise the sticky flag
    while (sb.fill < QDEPTH) begin
      if ($urandom_range(0, 11) == 0) send_op($urandom_range(0, 1) ? OP_DUMP_BWD : OP_DUMP_FWD,
                                               rand_word());
      else send_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_word());
    end
    send_op(OP_PUSH_FRONT, rand_word());
    send_op(OP_PUSH_BACK, rand_word());
    send_op(OP_DUMP_FWD, '0);
    send_op(OP_DUMP_BWD, '0);

    // Mostly pops, wrapping the ring
    run_mix(35, 6, 14, 6);

    // Final stretch without idling
    calm = 1'b1;
    run_mix(30, 12, 10, 8);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("double_ended_queue_unit test passed");
    end else begin
      $display("double_ended_queue_unit test failed");
    end
    $finish;
  end

  // Output side: check each transfer, then pick the next ready level
  initial begin : sink
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Cycle limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("double_ended_queue_unit test failed");
    $finish;
  end

endmodule
